FILE: rtl/core/atht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atht_pkg
// Shared constants, types and hash constants for the allocation tracking table.
// ----------------------------------------------------------------------------
package atht_pkg;

   localparam int unsigned TableSlotsDefault = 256;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_REALLOC = 2'd2;

   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_USED  = 2'd1;
   localparam logic [1:0] MARK_DEAD  = 2'd2;

   localparam logic [3:0] ST_RECORDED = 4'd0;
   localparam logic [3:0] ST_DROPPED  = 4'd1;
   localparam logic [3:0] ST_FREED    = 4'd2;
   localparam logic [3:0] ST_DOUBLE   = 4'd3;
   localparam logic [3:0] ST_UNTRACK  = 4'd4;
   localparam logic [3:0] ST_RESIZED  = 4'd5;
   localparam logic [3:0] ST_MOVED    = 4'd6;
   localparam logic [3:0] ST_REALLOC  = 4'd7;
   localparam logic [3:0] ST_IGNORED  = 4'd8;

   // classified command handed from front to back
   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_ALLOC   = 3'd1;
   localparam logic [2:0] CMD_FREE    = 3'd2;
   localparam logic [2:0] CMD_REALLOC = 3'd3;

   localparam logic [31:0] HashMulA = 32'h7feb352d;
   localparam logic [31:0] HashMulB = 32'h846ca68b;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] addr;
      logic [31:0] new_addr;
      logic [31:0] size;
      logic [31:0] file_tag;
      logic [15:0] line;
   } cmd_type;

   // record payload stored in the slot memory
   typedef struct packed {
      logic [31:0] addr;
      logic [31:0] bytes;
      logic [31:0] file;
      logic [15:0] line;
      logic [31:0] seq;
   } rec_type;

endpackage
`default_nettype wire

FILE: rtl/core/atht_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atht_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module atht_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

FILE: rtl/core/atht_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atht_front
// Accepts requests, classifies them and feeds a two-entry command queue.
// ----------------------------------------------------------------------------
module atht_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_op,
   input  wire logic [31:0]       req_addr,
   input  wire logic [31:0]       req_new_addr,
   input  wire logic [31:0]       req_size,
   input  wire logic [31:0]       req_file_tag,
   input  wire logic [15:0]       req_line,
   output logic                   q_valid,
   output atht_pkg::cmd_type      q_cmd,
   input  wire logic              q_pop
);
   atht_pkg::cmd_type cmd_in;
   atht_pkg::cmd_type ent_ff [2];
   atht_pkg::cmd_type ent_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   always_comb begin
      cmd_in.addr     = req_addr;
      cmd_in.new_addr = req_new_addr;
      cmd_in.size     = req_size;
      cmd_in.file_tag = req_file_tag;
      cmd_in.line     = req_line;
      cmd_in.cmd      = atht_pkg::CMD_NONE;
      unique case (req_op)
         atht_pkg::OP_ALLOC:
            if (req_addr != '0) cmd_in.cmd = atht_pkg::CMD_ALLOC;
         atht_pkg::OP_FREE:
            if (req_addr != '0) cmd_in.cmd = atht_pkg::CMD_FREE;
         atht_pkg::OP_REALLOC: begin
            // realloc of null acts as an alloc of new_addr; size zero as a free
            if (req_addr == '0) begin
               cmd_in.addr = req_new_addr;
               if (req_new_addr != '0) cmd_in.cmd = atht_pkg::CMD_ALLOC;
            end else if (req_size == '0) begin
               cmd_in.cmd = atht_pkg::CMD_FREE;
            end else if (req_new_addr != '0) begin
               cmd_in.cmd = atht_pkg::CMD_REALLOC;
            end
         end
         default: cmd_in.cmd = atht_pkg::CMD_NONE;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cmd     = ent_ff[0];

   always_comb begin
      ent_in = ent_ff;
      cnt_in = cnt_ff;
      if (q_pop) begin
         ent_in[0] = ent_ff[1];
         cnt_in    = cnt_in - 2'd1;
      end
      if (push) begin
         ent_in[cnt_in[0]] = cmd_in;
         cnt_in            = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
      ent_ff <= ent_in;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop of empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count lost a push");
endmodule
`default_nettype wire

FILE: rtl/core/atht_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atht_back
// Executes table commands with a probe sequencer over the slot memory.
// ----------------------------------------------------------------------------
module atht_back #(
   parameter int unsigned TABLE_SLOTS = atht_pkg::TableSlotsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire atht_pkg::cmd_type q_cmd,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [3:0]            rsp_status,
   output logic [7:0]            rsp_slot_index,
   output logic [31:0]           rsp_seq_used,
   output logic [8:0]            rsp_live_count,
   output logic [8:0]            rsp_dead_count,
   output logic [31:0]           rsp_dropped_total,
   output logic [31:0]           rsp_current_bytes,
   output logic [31:0]           rsp_peak_bytes,
   output logic [31:0]           rsp_alloc_total,
   output logic [31:0]           rsp_free_total,
   output logic [31:0]           rsp_realloc_total
);
   localparam int unsigned IW = $clog2(TABLE_SLOTS);
   localparam int unsigned CW = IW + 1;
   localparam int unsigned RW = $bits(atht_pkg::rec_type);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_HASH1 = 4'd1;
   localparam logic [3:0] S_HASH2 = 4'd2;
   localparam logic [3:0] S_HASH3 = 4'd3;
   localparam logic [3:0] S_RD    = 4'd4;
   localparam logic [3:0] S_CHK   = 4'd5;
   localparam logic [3:0] S_SCAN  = 4'd6;
   localparam logic [3:0] S_SCHK  = 4'd7;
   localparam logic [3:0] S_WR    = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;
   localparam logic [3:0] S_CLR   = 4'd11;

   // probe phases
   localparam logic [1:0] P_USED  = 2'd0;  // look for a used match
   localparam logic [1:0] P_FREE  = 2'd1;  // look for a free slot
   localparam logic [1:0] P_FREE2 = 2'd2;  // realloc target after retire

   logic [3:0]  st_ff, st_in;
   logic [1:0]  ph_ff, ph_in;
   atht_pkg::cmd_type c_ff, c_in;
   logic [31:0] h_ff, h_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] n_ff, n_in;
   atht_pkg::rec_type old_ff, old_in;
   logic        mk_we;
   logic [1:0]  mk_val;
   logic        ram_we;
   logic [IW-1:0] ram_addr;
   atht_pkg::rec_type ram_wd, ram_rd;
   logic [RW-1:0] ram_rd_bits;

   logic [31:0] seq_ff, seq_in;
   logic [8:0]  live_ff, live_in, dead_ff, dead_in;
   logic [31:0] drops_ff, drops_in, now_ff, now_in, peak_ff, peak_in;
   logic [31:0] alc_ff, alc_in, fre_ff, fre_in, rea_ff, rea_in;
   logic [3:0]  stat_ff, stat_in;
   logic [7:0]  slot_ff, slot_in;
   logic [31:0] sequ_ff, sequ_in;
   logic        bop_ff, bop_in;     // pending byte update
   logic        bsub_ff, bsub_in;
   logic [31:0] bamt_ff, bamt_in;
   logic [32:0] sum;
   logic [31:0] probe_key;
   logic [1:0]  cur_mark;

   atht_ram #(.WIDTH(RW), .DEPTH(TABLE_SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd_bits)
   );
   assign ram_rd = atht_pkg::rec_type'(ram_rd_bits);

   // slot marks share the record address; read data arrives in the next cycle
   atht_ram #(.WIDTH(2), .DEPTH(TABLE_SLOTS)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mk_we),
      .addr    (ram_addr),
      .wr_data (mk_val),
      .rd_data (cur_mark)
   );

   assign probe_key = (ph_ff == P_USED) ? c_ff.addr
                    : (c_ff.cmd == atht_pkg::CMD_REALLOC) ? c_ff.new_addr : c_ff.addr;
   assign sum = {1'b0, now_ff} + {1'b0, bamt_ff};

   assign rsp_valid         = (st_ff == S_OUT);
   assign rsp_status        = stat_ff;
   assign rsp_slot_index    = slot_ff;
   assign rsp_seq_used      = sequ_ff;
   assign rsp_live_count    = live_ff;
   assign rsp_dead_count    = dead_ff;
   assign rsp_dropped_total = drops_ff;
   assign rsp_current_bytes = now_ff;
   assign rsp_peak_bytes    = peak_ff;
   assign rsp_alloc_total   = alc_ff;
   assign rsp_free_total    = fre_ff;
   assign rsp_realloc_total = rea_ff;

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; c_in = c_ff; h_in = h_ff;
      idx_in = idx_ff; n_in = n_ff; old_in = old_ff;
      seq_in = seq_ff; live_in = live_ff; dead_in = dead_ff; drops_in = drops_ff;
      now_in = now_ff; peak_in = peak_ff; alc_in = alc_ff; fre_in = fre_ff; rea_in = rea_ff;
      stat_in = stat_ff; slot_in = slot_ff; sequ_in = sequ_ff;
      bop_in = bop_ff; bsub_in = bsub_ff; bamt_in = bamt_ff;
      q_pop = 1'b0; mk_we = 1'b0; mk_val = atht_pkg::MARK_USED;
      ram_we = 1'b0; ram_addr = idx_ff;
      ram_wd.addr = probe_key; ram_wd.bytes = c_ff.size; ram_wd.file = c_ff.file_tag;
      ram_wd.line = c_ff.line; ram_wd.seq = seq_ff;
      unique case (st_ff)
         S_CLR: begin
            // clearing pass: mark every slot empty after reset
            mk_we = 1'b1; mk_val = atht_pkg::MARK_EMPTY;
            if (idx_ff == IW'(TABLE_SLOTS - 1)) begin
               idx_in = '0; st_in = S_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_IDLE: if (q_valid) begin
            q_pop = 1'b1;
            c_in = q_cmd;
            stat_in = atht_pkg::ST_IGNORED; slot_in = '0; sequ_in = '0; bop_in = 1'b0;
            ph_in = (q_cmd.cmd == atht_pkg::CMD_ALLOC) ? P_FREE : P_USED;
            h_in = q_cmd.addr >> 2;
            if (q_cmd.cmd == atht_pkg::CMD_NONE) st_in = S_OUT;
            else st_in = S_HASH1;
         end
         S_HASH1: begin
            h_in = (h_ff ^ (h_ff >> 16)) * atht_pkg::HashMulA;
            st_in = S_HASH2;
         end
         S_HASH2: begin
            h_in = (h_ff ^ (h_ff >> 15)) * atht_pkg::HashMulB;
            st_in = S_HASH3;
         end
         S_HASH3: begin
            idx_in = IW'((h_ff ^ (h_ff >> 16)) % TABLE_SLOTS);
            n_in = '0;
            st_in = S_RD;
         end
         S_RD: st_in = S_CHK;  // memory read in flight
         S_CHK: begin
            st_in = S_RD;
            idx_in = (32'(idx_ff) + 32'd1 >= TABLE_SLOTS) ? '0 : idx_ff + IW'(1);
            n_in = n_ff + CW'(1);
            if (ph_ff == P_USED) begin
               if (cur_mark == atht_pkg::MARK_USED && ram_rd.addr == c_ff.addr) begin
                  old_in = ram_rd;
                  idx_in = idx_ff;
                  if (c_ff.cmd == atht_pkg::CMD_FREE) begin
                     mk_we = 1'b1; mk_val = atht_pkg::MARK_DEAD;
                     live_in = live_ff - 9'd1; dead_in = dead_ff + 9'd1;
                     fre_in = fre_ff + 32'd1;
                     bop_in = 1'b1; bsub_in = 1'b1; bamt_in = ram_rd.bytes;
                     stat_in = atht_pkg::ST_FREED; slot_in = 8'(idx_ff);
                     st_in = S_DONE;
                  end else if (c_ff.new_addr == c_ff.addr) begin
                     st_in = S_WR;
                  end else begin
                     // moved: retire old slot, then probe for the new address
                     mk_we = 1'b1; mk_val = atht_pkg::MARK_DEAD;
                     live_in = live_ff - 9'd1; dead_in = dead_ff + 9'd1;
                     ph_in = P_FREE2;
                     h_in = c_ff.new_addr >> 2;
                     st_in = S_HASH1;
                  end
               end else if (cur_mark == atht_pkg::MARK_EMPTY ||
                            n_ff == CW'(TABLE_SLOTS - 1)) begin
                  if (c_ff.cmd == atht_pkg::CMD_FREE) begin
                     idx_in = '0; n_in = '0; st_in = S_SCAN;
                  end else begin
                     ph_in = P_FREE; h_in = c_ff.new_addr >> 2; st_in = S_HASH1;
                  end
               end
            end else begin
               if (cur_mark != atht_pkg::MARK_USED) begin
                  idx_in = idx_ff;
                  st_in = S_WR;
               end else if (n_ff == CW'(TABLE_SLOTS - 1)) begin
                  if (c_ff.cmd == atht_pkg::CMD_ALLOC) begin
                     drops_in = drops_ff + 32'd1; stat_in = atht_pkg::ST_DROPPED;
                  end
                  st_in = S_DONE;
               end
            end
         end
         S_SCAN: st_in = S_SCHK;
         S_SCHK: begin
            if (cur_mark == atht_pkg::MARK_DEAD && ram_rd.addr == c_ff.addr) begin
               stat_in = atht_pkg::ST_DOUBLE; st_in = S_DONE;
            end else if (n_ff == CW'(TABLE_SLOTS - 1)) begin
               stat_in = atht_pkg::ST_UNTRACK; st_in = S_DONE;
            end else begin
               idx_in = idx_ff + IW'(1); n_in = n_ff + CW'(1); st_in = S_SCAN;
            end
         end
         S_WR: begin
            ram_we = 1'b1;
            sequ_in = seq_ff; seq_in = seq_ff + 32'd1; slot_in = 8'(idx_ff);
            if (c_ff.cmd == atht_pkg::CMD_REALLOC && ph_ff == P_USED) begin
               // resize in place
               ram_wd = old_ff; ram_wd.bytes = c_ff.size; ram_wd.seq = seq_ff;
               rea_in = rea_ff + 32'd1; stat_in = atht_pkg::ST_RESIZED;
               bop_in = 1'b1; bsub_in = (c_ff.size <= old_ff.bytes);
               bamt_in = bsub_in ? old_ff.bytes - c_ff.size : c_ff.size - old_ff.bytes;
            end else begin
               mk_we = 1'b1; mk_val = atht_pkg::MARK_USED;
               live_in = live_ff + 9'd1;
               if (cur_mark == atht_pkg::MARK_DEAD && dead_ff != '0)
                  dead_in = dead_ff - 9'd1;
               bop_in = 1'b1; bsub_in = 1'b0; bamt_in = c_ff.size;
               if (c_ff.cmd == atht_pkg::CMD_ALLOC) begin
                  alc_in = alc_ff + 32'd1; stat_in = atht_pkg::ST_RECORDED;
               end else if (ph_ff == P_FREE2) begin
                  ram_wd.file = old_ff.file; ram_wd.line = old_ff.line;
                  rea_in = rea_ff + 32'd1; stat_in = atht_pkg::ST_MOVED;
                  bsub_in = (c_ff.size <= old_ff.bytes);
                  bamt_in = bsub_in ? old_ff.bytes - c_ff.size : c_ff.size - old_ff.bytes;
               end else begin
                  ram_wd.file = '0; ram_wd.line = '0;
                  rea_in = rea_ff + 32'd1; stat_in = atht_pkg::ST_REALLOC;
               end
            end
            st_in = S_DONE;
         end
         S_DONE: begin
            if (bop_ff) begin
               if (bsub_ff) now_in = (now_ff < bamt_ff) ? '0 : now_ff - bamt_ff;
               else begin
                  now_in = sum[32] ? '1 : sum[31:0];
                  if (now_in > peak_ff) peak_in = now_in;
               end
            end
            bop_in = 1'b0;
            st_in = S_OUT;
         end
         S_OUT: if (!rsp_stall) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR; idx_ff <= '0; seq_ff <= 32'd1; live_ff <= '0; dead_ff <= '0;
         drops_ff <= '0; now_ff <= '0; peak_ff <= '0;
         alc_ff <= '0; fre_ff <= '0; rea_ff <= '0; bop_ff <= 1'b0;
      end else begin
         st_ff <= st_in; idx_ff <= idx_in; seq_ff <= seq_in; live_ff <= live_in;
         dead_ff <= dead_in;
         drops_ff <= drops_in; now_ff <= now_in; peak_ff <= peak_in;
         alc_ff <= alc_in; fre_ff <= fre_in; rea_ff <= rea_in; bop_ff <= bop_in;
      end
      ph_ff <= ph_in; c_ff <= c_in; h_ff <= h_in;
      n_ff <= n_in; old_ff <= old_in; stat_ff <= stat_in;
      slot_ff <= slot_in; sequ_ff <= sequ_in; bsub_ff <= bsub_in; bamt_ff <= bamt_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped under stall");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> st_ff == S_IDLE)
      else $error("command taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      peak_ff >= now_ff)
      else $error("peak below current bytes");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_WR && c_ff.cmd == atht_pkg::CMD_ALLOC) |-> cur_mark != atht_pkg::MARK_USED)
      else $error("alloc over a used slot");
endmodule
`default_nettype wire

FILE: rtl/core/allocation_tracking_hash_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// allocation_tracking_hash_table
// Tracks live allocations in a linear-probed table with tombstones.
// ----------------------------------------------------------------------------
// Requests (req_*) carry op, addresses, size and caller info; one response
// (rsp_*) follows each request, in order. Both channels use valid/stall.
// A front stage classifies requests into a two-entry queue, so up to two
// requests are taken while the back end is busy or the receiver stalls.
// The back end handles one request at a time: it takes the request and
// hashes it (S_HASH1, S_HASH2, S_HASH3), then reads and checks each probed
// slot (registered slot memory read), finishes a free directly or writes a
// record first, then the response is presented. An ignored request goes
// straight to its response. A move hashes again before probing for the
// new address. A full-table probe or the double-free scan visits up to
// TABLE_SLOTS slots each. The next request is taken the cycle after the
// response leaves.
// After reset a clearing pass marks all TABLE_SLOTS slots empty, one per
// cycle; requests queue meanwhile. While rsp_stall is high the response
// holds and the back end waits.
// ----------------------------------------------------------------------------
module allocation_tracking_hash_table #(
   parameter int unsigned TABLE_SLOTS = atht_pkg::TableSlotsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_addr,
   input  wire logic [31:0] req_new_addr,
   input  wire logic [31:0] req_size,
   input  wire logic [31:0] req_file_tag,
   input  wire logic [15:0] req_line,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_status,
   output logic [7:0]       rsp_slot_index,
   output logic [31:0]      rsp_seq_used,
   output logic [8:0]       rsp_live_count,
   output logic [8:0]       rsp_dead_count,
   output logic [31:0]      rsp_dropped_total,
   output logic [31:0]      rsp_current_bytes,
   output logic [31:0]      rsp_peak_bytes,
   output logic [31:0]      rsp_alloc_total,
   output logic [31:0]      rsp_free_total,
   output logic [31:0]      rsp_realloc_total
);
   logic              q_valid, q_pop;
   atht_pkg::cmd_type q_cmd;

   atht_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_addr, .req_new_addr,
      .req_size, .req_file_tag, .req_line, .q_valid, .q_cmd, .q_pop
   );

   atht_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_pop, .rsp_valid, .rsp_stall,
      .rsp_status, .rsp_slot_index, .rsp_seq_used, .rsp_live_count, .rsp_dead_count,
      .rsp_dropped_total, .rsp_current_bytes, .rsp_peak_bytes, .rsp_alloc_total,
      .rsp_free_total, .rsp_realloc_total
   );
endmodule
`default_nettype wire
